[hdl/afsk_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the AFSK tone correlator.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package afsk_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int STEP_W          = 31;
   localparam int PHASE_W         = 32;
   localparam int WINDOW_LENGTH   = 40;
   localparam int TABLE_ADDR_BITS = 10;

   localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
   localparam int PTR_W        = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   // exact window sum of WINDOW_LENGTH Q15 products
   localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int PROD_W       = 2 * SUM_W;
   localparam int ACC_W        = PROD_W + 2;
   localparam int LANES        = 4;
   localparam int HIST_W       = LANES * SAMPLE_W;

   localparam logic [STEP_W-1:0] MARK_STEP_RESET  = 31'd107374182;
   localparam logic [STEP_W-1:0] SPACE_STEP_RESET = 31'd196852668;

   // register indexes
   localparam logic CSR_MARK_STEP  = 1'b0;
   localparam logic CSR_SPACE_STEP = 1'b1;

   localparam logic [TABLE_ADDR_BITS-1:0] QUARTER_ADDR = TABLE_ADDR_BITS'(QUARTER_LEN);
   localparam logic [QUARTER_BITS:0]      QUARTER_X    = (QUARTER_BITS + 1)'(QUARTER_LEN);

   // Taylor coefficients of sin(pi/2 * z), Q30
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint POLY_A1 = 64'sd1686629713;
   localparam longint POLY_A3 = -64'sd693598668;
   localparam longint POLY_A5 = 64'sd85569300;
   localparam longint POLY_A7 = -64'sd5026988;
   localparam longint POLY_A9 = 64'sd172272;

   typedef logic [SAMPLE_W-2:0] quarter_rom_type [QUARTER_LEN];

   typedef struct packed {
      logic mul_en;
      logic acc_clear;
      logic acc_add;
      logic acc_sub;
   } mac_ctrl_type;

   // Q15 magnitude of the quarter wave at step x of QUARTER_LEN, rounded half up
   function automatic logic [SAMPLE_W-2:0] quarter_sine(input int x);
      longint z;
      longint z2;
      longint p;
      longint s;
      z  = longint'(x) <<< (30 - QUARTER_BITS);
      z2 = (z * z) / Q30_ONE;
      p  = POLY_A9;
      p  = POLY_A7 + (p * z2) / Q30_ONE;
      p  = POLY_A5 + (p * z2) / Q30_ONE;
      p  = POLY_A3 + (p * z2) / Q30_ONE;
      p  = POLY_A1 + (p * z2) / Q30_ONE;
      s  = (z * p) / Q30_ONE;
      if (s < 0) begin
         s = 0;
      end
      s = (s + 64'sd16384) / 64'sd32768;
      if (s > 64'sd32767) begin
         s = 64'sd32767;
      end
      return s[SAMPLE_W-2:0];
   endfunction

   function automatic quarter_rom_type build_quarter_rom();
      quarter_rom_type rom;
      for (int i = 0; i < QUARTER_LEN; i++) begin
         rom[i] = quarter_sine(i);
      end
      return rom;
   endfunction

   localparam quarter_rom_type     QUARTER_ROM  = build_quarter_rom();
   // value at exactly a quarter turn, one past the end of the table
   localparam logic [SAMPLE_W-2:0] QUARTER_PEAK = quarter_sine(QUARTER_LEN);

endpackage

[hdl/afsk_sine_rom.sv]
// Registered sine lookup: quarter-wave table with mirroring and sign for the full turn.
// Depends on afsk_pkg for the table and its widths.

module afsk_sine_rom (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [afsk_pkg::TABLE_ADDR_BITS-1:0]  addr,
   output logic signed [afsk_pkg::SAMPLE_W-1:0]  value
);

   logic [1:0]                          quadrant;
   logic [afsk_pkg::QUARTER_BITS-1:0]   fraction;
   logic [afsk_pkg::QUARTER_BITS:0]     x;
   logic [afsk_pkg::SAMPLE_W-2:0]       magnitude;
   logic signed [afsk_pkg::SAMPLE_W-1:0] value_in;
   logic signed [afsk_pkg::SAMPLE_W-1:0] value_ff;

   assign quadrant = addr[afsk_pkg::TABLE_ADDR_BITS-1 -: 2];
   assign fraction = addr[afsk_pkg::QUARTER_BITS-1:0];

   always_comb begin
      // odd quadrants run the quarter wave backward
      x = quadrant[0] ? (afsk_pkg::QUARTER_X - {1'b0, fraction}) : {1'b0, fraction};
      magnitude = x[afsk_pkg::QUARTER_BITS] ? afsk_pkg::QUARTER_PEAK
                                           : afsk_pkg::QUARTER_ROM[x[afsk_pkg::QUARTER_BITS-1:0]];
      value_in = quadrant[1] ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

[hdl/afsk_hist_mem.sv]
// Product history: one word of four Q15 products per window slot, registered read.
// Depends on afsk_pkg; per-slot valid bits make unwritten slots read as zero after reset.

module afsk_hist_mem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [afsk_pkg::PTR_W-1:0]        rd_addr,
   output logic [afsk_pkg::HIST_W-1:0]       rd_data,
   input  logic                              wr_en,
   input  logic [afsk_pkg::PTR_W-1:0]        wr_addr,
   input  logic [afsk_pkg::HIST_W-1:0]       wr_data
);

   logic [afsk_pkg::HIST_W-1:0] mem [afsk_pkg::WINDOW_LENGTH];
   logic [afsk_pkg::WINDOW_LENGTH-1:0] valid_ff;
   logic [afsk_pkg::HIST_W-1:0] rd_word_ff;
   logic                        rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

[hdl/afsk_mac.sv]
// Shared signed multiplier with a registered product and an energy difference accumulator.
// Depends on afsk_pkg for widths and the control struct.

module afsk_mac (
   input  logic                                clock,
   input  afsk_pkg::mac_ctrl_type              ctrl,
   input  logic signed [afsk_pkg::SUM_W-1:0]   op_a,
   input  logic signed [afsk_pkg::SUM_W-1:0]   op_b,
   output logic signed [afsk_pkg::PROD_W-1:0]  prod,
   output logic signed [afsk_pkg::ACC_W-1:0]   acc
);

   logic signed [afsk_pkg::PROD_W-1:0] prod_ff;
   logic signed [afsk_pkg::ACC_W-1:0]  acc_ff;
   logic signed [afsk_pkg::ACC_W-1:0]  prod_ext;

   assign prod_ext = {{(afsk_pkg::ACC_W - afsk_pkg::PROD_W){prod_ff[afsk_pkg::PROD_W-1]}},
                      prod_ff};

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_add) begin
         acc_ff <= acc_ff + prod_ext;
      end else if (ctrl.acc_sub) begin
         acc_ff <= acc_ff - prod_ext;
      end
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

[hdl/afsk_tone_correlator.sv]
// Top level of the AFSK tone correlator: sequencer, phase accumulators and window sums.
// Depends on afsk_pkg, afsk_sine_rom, afsk_hist_mem and afsk_mac.
//
//   channel  ports                                   direction  word
//   req      req_valid req_stall req_audio_sample    in         one Q15 sample
//   rsp      rsp_valid rsp_stall rsp_tone_bit        out        one tone bit per sample
//   csr      csr_we csr_index csr_wdata              in         phase step write
//
// Each sample runs through the one shared multiplier in turn: four table products
// (lookup, multiply, sum update) and four squares (square, energy accumulate), then a
// retire state that waits while the rsp register is full and stalled. A new sample is
// taken only once the last one has retired; req_stall is high while busy.
// Reset is synchronous; history valid bits clear at once, so no clearing pass.
// A finished bit waits in the rsp register; a new sample is taken meanwhile.

module afsk_tone_correlator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [afsk_pkg::SAMPLE_W-1:0] req_audio_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_tone_bit,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [afsk_pkg::STEP_W-1:0]          csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MUL,
      ST_SUM,
      ST_SQUARE,
      ST_ENERGY,
      ST_DONE
   } state_type;

   localparam int SW = afsk_pkg::SAMPLE_W;
   localparam int TB = afsk_pkg::TABLE_ADDR_BITS;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_tone_bit_ff;

   logic [afsk_pkg::STEP_W-1:0]  mark_step_ff;
   logic [afsk_pkg::STEP_W-1:0]  space_step_ff;
   logic [afsk_pkg::PHASE_W-1:0] mark_phase_ff;
   logic [afsk_pkg::PHASE_W-1:0] space_phase_ff;
   logic [TB-1:0]                mark_addr_ff;
   logic [TB-1:0]                space_addr_ff;
   logic signed [SW-1:0]         sample_ff;
   logic [1:0]                   lane_ff;
   logic [afsk_pkg::PTR_W-1:0]   ptr_ff;
   logic [afsk_pkg::PTR_W-1:0]   ptr_in;
   logic signed [afsk_pkg::SUM_W-1:0] sums_ff [afsk_pkg::LANES];
   logic signed [afsk_pkg::SUM_W-1:0] sum_in;
   logic [afsk_pkg::HIST_W-1:0]  new_hist_ff;

   logic                         accept;
   logic                         finish;
   logic [TB-1:0]                rom_addr;
   logic signed [SW-1:0]         rom_value;
   logic [afsk_pkg::HIST_W-1:0]  hist_rd_data;
   logic [SW-1:0]                prod_q15;
   logic [SW-1:0]                old_q15;
   logic signed [afsk_pkg::SUM_W-1:0] op_a;
   logic signed [afsk_pkg::SUM_W-1:0] op_b;
   logic signed [afsk_pkg::PROD_W-1:0] mac_prod;
   logic signed [afsk_pkg::ACC_W-1:0]  mac_acc;
   afsk_pkg::mac_ctrl_type       mac_ctrl;
   logic                         tone_in;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign finish    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      rom_addr = (lane_ff[1] ? space_addr_ff : mark_addr_ff)
               + (lane_ff[0] ? afsk_pkg::QUARTER_ADDR : {TB{1'b0}});
      // floor(sample * table / 2^15), kept to 16 bits
      prod_q15 = mac_prod[2*SW-2 -: SW];
      old_q15  = hist_rd_data[{lane_ff, 4'b0000} +: SW];
      sum_in   = sums_ff[lane_ff]
               + {{(afsk_pkg::SUM_W - SW){prod_q15[SW-1]}}, prod_q15}
               - {{(afsk_pkg::SUM_W - SW){old_q15[SW-1]}}, old_q15};
      if (state_ff == ST_SQUARE) begin
         op_a = sums_ff[lane_ff];
         op_b = sums_ff[lane_ff];
      end else begin
         op_a = {{(afsk_pkg::SUM_W - SW){sample_ff[SW-1]}}, sample_ff};
         op_b = {{(afsk_pkg::SUM_W - SW){rom_value[SW-1]}}, rom_value};
      end
      mac_ctrl.mul_en    = (state_ff == ST_MUL) || (state_ff == ST_SQUARE);
      mac_ctrl.acc_clear = accept;
      // mark squares add, space squares subtract
      mac_ctrl.acc_add   = (state_ff == ST_ENERGY) && !lane_ff[1];
      mac_ctrl.acc_sub   = (state_ff == ST_ENERGY) && lane_ff[1];
      ptr_in  = (ptr_ff == afsk_pkg::PTR_W'(afsk_pkg::WINDOW_LENGTH - 1))
              ? '0 : ptr_ff + 1'b1;
      tone_in = !mac_acc[afsk_pkg::ACC_W-1] && (mac_acc != '0);
   end

   afsk_sine_rom u_rom (
      .clock (clock),
      .rd_en (state_ff == ST_LOOK),
      .addr  (rom_addr),
      .value (rom_value)
   );

   afsk_hist_mem u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ptr_ff),
      .rd_data (hist_rd_data),
      .wr_en   (finish),
      .wr_addr (ptr_ff),
      .wr_data (new_hist_ff)
   );

   afsk_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         lane_ff        <= '0;
         ptr_ff         <= '0;
         mark_step_ff   <= afsk_pkg::MARK_STEP_RESET;
         space_step_ff  <= afsk_pkg::SPACE_STEP_RESET;
         mark_phase_ff  <= '0;
         space_phase_ff <= '0;
         for (int i = 0; i < afsk_pkg::LANES; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               afsk_pkg::CSR_MARK_STEP:  mark_step_ff  <= csr_wdata;
               afsk_pkg::CSR_SPACE_STEP: space_step_ff <= csr_wdata;
               default: ;
            endcase
         end
         // a retiring sample refills the rsp register in the same cycle
         if (rsp_valid_ff && !rsp_stall && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sample_ff      <= req_audio_sample;
                  mark_addr_ff   <= mark_phase_ff[afsk_pkg::PHASE_W-1 -: TB];
                  space_addr_ff  <= space_phase_ff[afsk_pkg::PHASE_W-1 -: TB];
                  mark_phase_ff  <= mark_phase_ff + {1'b0, mark_step_ff};
                  space_phase_ff <= space_phase_ff + {1'b0, space_step_ff};
                  lane_ff        <= '0;
                  state_ff       <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sums_ff[lane_ff]                    <= sum_in;
               new_hist_ff[{lane_ff, 4'b0000} +: SW] <= prod_q15;
               lane_ff                             <= lane_ff + 2'd1;
               state_ff <= (lane_ff == 2'd3) ? ST_SQUARE : ST_LOOK;
            end
            ST_SQUARE: begin
               state_ff <= ST_ENERGY;
            end
            ST_ENERGY: begin
               lane_ff  <= lane_ff + 2'd1;
               state_ff <= (lane_ff == 2'd3) ? ST_DONE : ST_SQUARE;
            end
            ST_DONE: begin
               if (finish) begin
                  rsp_tone_bit_ff <= tone_in;
                  rsp_valid_ff    <= 1'b1;
                  ptr_ff          <= ptr_in;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tone_bit = rsp_tone_bit_ff;

endmodule
